### rtl/gwmf_pkg.sv
package gwmf_pkg;

    // default sizes of the stores
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_WINDOW_DEF = 256;
    localparam int MAX_HEIGHT_DEF = 1024;

    // fixed field widths
    localparam int CNT_W      = 9;
    localparam int HEIGHT_W   = 11;
    localparam int WIDTH_W    = 9;
    localparam int WIN_W      = 9;
    localparam int CELL_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int REM_W      = WIN_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd2;

    // cell kinds
    localparam logic [CELL_W-1:0] CELL_OPEN    = 2'd0;
    localparam logic [CELL_W-1:0] CELL_FILL    = 2'd1;
    localparam logic [CELL_W-1:0] CELL_BLOCKED = 2'd2;

    // per-item window control
    typedef struct packed {
        logic first;
        logic sub;
        logic offer;
    } t_win_ctl;

    // candidate window from one direction
    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] fill;
    } t_cand;

    // remainder unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_sts;

    // sliding count: drop the leaving cell, add the new one
    function automatic logic [CNT_W-1:0] cnt_next(
        input logic [CNT_W-1:0]  base,
        input logic              sub,
        input logic [CELL_W-1:0] old_cell,
        input logic [CELL_W-1:0] new_cell,
        input logic [CELL_W-1:0] kind
    );
        logic [CNT_W-1:0] t;
        t        = base - CNT_W'(sub && (old_cell == kind));
        cnt_next = t + CNT_W'(new_cell == kind);
    endfunction

    // one restoring remainder step
    function automatic logic [REM_W-1:0] rem_step(
        input logic [REM_W-1:0] rem,
        input logic             din,
        input logic [WIN_W-1:0] div
    );
        logic [REM_W-1:0] t;
        t = {rem[REM_W-2:0], din};
        if (t >= {1'b0, div}) begin
            rem_step = t - {1'b0, div};
        end else begin
            rem_step = t;
        end
    endfunction

endpackage

### rtl/grid_window_min_fill_search.sv
// a grid's result goes through the s1, s2 and output registers after its last cell
// throughput: one cell per cycle when not held off; the row ring and column store are
//   read on accept and written back from stage one, forwarding between neighbor cells
// a window_len write holds off cells for the remainder recompute
// reset: synchronous active low; indices, counts and count valid bits clear,
//   registers go to 1, the row ring and column store keep their contents
module grid_window_min_fill_search #(
    parameter int MAX_WIDTH  = gwmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = gwmf_pkg::MAX_WINDOW_DEF,
    parameter int MAX_HEIGHT = gwmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [1:0] cell_req
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,   // [0] found, [9:1] min_fill
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gwmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gwmf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gwmf_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RW = ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1) + 1;

    // configuration
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  r_width;
    logic [WIN_W-1:0]    r_wlen;
    logic                r_mod_start;
    logic [HEIGHT_W-1:0] h_eff;
    logic [WIDTH_W-1:0]  w_eff;
    logic [WIN_W-1:0]    l_eff;
    logic                cfg_wr;

    // grid position of the next cell
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [WW-1:0] r_cmod;
    logic [WW-1:0] r_rmod;

    // pipeline
    logic     stall;
    logic     adv;
    logic     acc;
    logic     r_s1_valid;
    logic     r_s1_last;
    logic     r_s2_valid;
    logic     r_s2_last;
    t_cand    r_s2_h;
    t_cand    r_s2_v;
    t_cand    h_cand;
    t_cand    v_cand;
    t_win_ctl h_ctl;
    t_win_ctl v_ctl;

    // current cell position
    logic          wrap0;
    logic          end_row;
    logic          last;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [WW-1:0] cur_cmod;
    logic [WW-1:0] cur_rmod;

    // best window
    logic             r_best_valid;
    logic [CNT_W-1:0] r_best_fill;
    logic             n_best_valid;
    logic [CNT_W-1:0] n_best_fill;

    // result register
    logic             r_out_valid;
    logic             r_out_found;
    logic [CNT_W-1:0] r_out_min;

    // remainder unit
    t_mod_sts      mod_sts;
    logic [WW-1:0] mod_row_rem;
    logic [WW-1:0] mod_col_rem;

    function automatic logic [WW-1:0] mod_inc(
        input logic [WW-1:0]    x,
        input logic [WIN_W-1:0] len
    );
        if (32'(x) + 32'd1 >= 32'(len)) begin
            mod_inc = '0;
        end else begin
            mod_inc = x + 1'b1;
        end
    endfunction

    // clamped registers
    always_comb begin
        if (r_height == '0) begin
            h_eff = HEIGHT_W'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        if (r_width == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_wlen == '0) begin
            l_eff = WIN_W'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            l_eff = WIN_W'(MAX_WINDOW);
        end else begin
            l_eff = r_wlen;
        end
    end

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign stall         = r_s2_valid && r_s2_last && r_out_valid && !m_axis_tready;
    assign adv           = !stall;
    assign s_axis_tready = adv && !r_mod_start && !mod_sts.busy && !mod_sts.done;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= HEIGHT_W'(1);
            r_width     <= WIDTH_W'(1);
            r_wlen      <= WIN_W'(1);
            r_mod_start <= 1'b0;
        end else begin
            r_mod_start <= 1'b0;
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_GRID_HEIGHT: r_height <= i_cfg_data;
                    CFG_GRID_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_WINDOW_LEN: begin
                        r_wlen      <= i_cfg_data[WIN_W-1:0];
                        r_mod_start <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // position of the incoming cell and its window controls
    always_comb begin
        wrap0    = 32'(r_col) >= 32'(w_eff);
        cur_col  = wrap0 ? '0 : r_col;
        cur_row  = wrap0 ? r_row + 1'b1 : r_row;
        cur_cmod = wrap0 ? '0 : r_cmod;
        cur_rmod = wrap0 ? mod_inc(r_rmod, l_eff) : r_rmod;
        end_row  = 32'(cur_col) + 32'd1 >= 32'(w_eff);
        last     = end_row && (32'(cur_row) + 32'd1 >= 32'(h_eff));

        h_ctl.first = (cur_col == '0);
        h_ctl.sub   = 32'(cur_col) >= 32'(l_eff);
        h_ctl.offer = 32'(cur_col) + 32'd1 >= 32'(l_eff);
        v_ctl.first = (cur_row == '0);
        v_ctl.sub   = 32'(cur_row) >= 32'(l_eff);
        v_ctl.offer = 32'(cur_row) + 32'd1 >= 32'(l_eff);
    end

    // advance the grid position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cmod <= '0;
            r_rmod <= '0;
        end else if (acc) begin
            if (last) begin
                r_col  <= '0;
                r_row  <= '0;
                r_cmod <= '0;
                r_rmod <= '0;
            end else if (end_row) begin
                r_col  <= '0;
                r_row  <= cur_row + 1'b1;
                r_cmod <= '0;
                r_rmod <= mod_inc(cur_rmod, l_eff);
            end else begin
                r_col  <= cur_col + 1'b1;
                r_row  <= cur_row;
                r_cmod <= mod_inc(cur_cmod, l_eff);
                r_rmod <= cur_rmod;
            end
        end else if (mod_sts.done) begin
            r_cmod <= mod_col_rem;
            r_rmod <= mod_row_rem;
        end
    end

    // ring slots realigned after a window length change
    gwmf_mod_unit #(
        .RW (RW),
        .CW (CW),
        .WW (WW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mod_start),
        .i_divisor (l_eff),
        .i_row     (r_row),
        .i_col     (r_col),
        .o_sts     (mod_sts),
        .o_row_rem (mod_row_rem),
        .o_col_rem (mod_col_rem)
    );

    // horizontal window
    gwmf_row_win #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_acc   (acc),
        .i_cell  (s_axis_tdata[CELL_W-1:0]),
        .i_pos   (cur_cmod),
        .i_ctl   (h_ctl),
        .o_cand  (h_cand)
    );

    // vertical window
    gwmf_col_win #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_acc   (acc),
        .i_cell  (s_axis_tdata[CELL_W-1:0]),
        .i_col   (cur_col),
        .i_pos   (cur_rmod),
        .i_ctl   (v_ctl),
        .o_cand  (v_cand)
    );

    // stage valids and candidate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= acc;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_last <= last;
        end
        if (adv) begin
            r_s2_last <= r_s1_last;
            r_s2_h    <= h_cand;
            r_s2_v    <= v_cand;
        end
    end

    // least fill over both candidates
    always_comb begin
        n_best_valid = r_best_valid;
        n_best_fill  = r_best_fill;
        if (r_s2_h.ok && (!n_best_valid || r_s2_h.fill < n_best_fill)) begin
            n_best_valid = 1'b1;
            n_best_fill  = r_s2_h.fill;
        end
        if (r_s2_v.ok && (!n_best_valid || r_s2_v.fill < n_best_fill)) begin
            n_best_valid = 1'b1;
            n_best_fill  = r_s2_v.fill;
        end
    end

    // best tracking and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_fill  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv && r_s2_valid) begin
                if (r_s2_last) begin
                    r_best_valid <= 1'b0;
                    r_best_fill  <= '0;
                    r_out_valid  <= 1'b1;
                end else begin
                    r_best_valid <= n_best_valid;
                    r_best_fill  <= n_best_fill;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_last) begin
            r_out_found <= n_best_valid;
            if (!n_best_valid) begin
                r_out_min <= '0;
            end else if (n_best_fill > l_eff) begin
                r_out_min <= l_eff;
            end else begin
                r_out_min <= n_best_fill;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_min, r_out_found};

endmodule

### rtl/gwmf_row_win.sv
module gwmf_row_win #(
    parameter int MAX_WINDOW = gwmf_pkg::MAX_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_acc,
    input  logic [gwmf_pkg::CELL_W-1:0] i_cell,
    input  logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] i_pos,
    input  gwmf_pkg::t_win_ctl          i_ctl,
    output gwmf_pkg::t_cand             o_cand
);
    import gwmf_pkg::*;

    localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CELL_W-1:0] r_ring [MAX_WINDOW];
    logic [CELL_W-1:0] r_ring_q;

    logic              r_s1_valid;
    logic [CELL_W-1:0] r_s1_cell;
    logic [WW-1:0]     r_s1_pos;
    t_win_ctl          r_s1_ctl;
    logic              r_fwd;
    logic [CELL_W-1:0] r_fwd_cell;

    logic [CNT_W-1:0]  r_blk;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_blk;
    logic [CNT_W-1:0]  n_fill;
    logic [CELL_W-1:0] old_cell;

    // row ring: write back the stage-one cell, read for the new request
    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            r_ring[r_s1_pos] <= r_s1_cell;
        end
        if (i_acc) begin
            r_ring_q <= r_ring[i_pos];
        end
    end

    // stage-one payload, with forwarding when the ring slot is being written
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_cell  <= i_cell;
            r_s1_pos   <= i_pos;
            r_s1_ctl   <= i_ctl;
            r_fwd      <= r_s1_valid && (r_s1_pos == i_pos);
            r_fwd_cell <= r_s1_cell;
        end
    end

    // leaving cell and updated row counts
    always_comb begin
        old_cell = r_fwd ? r_fwd_cell : r_ring_q;
        n_blk    = cnt_next(r_s1_ctl.first ? '0 : r_blk, r_s1_ctl.sub,
                            old_cell, r_s1_cell, CELL_BLOCKED);
        n_fill   = cnt_next(r_s1_ctl.first ? '0 : r_fill, r_s1_ctl.sub,
                            old_cell, r_s1_cell, CELL_FILL);
    end

    // stage-one valid and running counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_blk      <= '0;
            r_fill     <= '0;
        end else if (i_adv) begin
            r_s1_valid <= i_acc;
            if (r_s1_valid) begin
                r_blk  <= n_blk;
                r_fill <= n_fill;
            end
        end
    end

    // full window with nothing blocked
    assign o_cand.ok   = r_s1_valid && r_s1_ctl.offer && (n_blk == '0);
    assign o_cand.fill = n_fill;

endmodule

### rtl/gwmf_col_win.sv
module gwmf_col_win #(
    parameter int MAX_WIDTH  = gwmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = gwmf_pkg::MAX_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_acc,
    input  logic [gwmf_pkg::CELL_W-1:0] i_cell,
    input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] i_col,
    input  logic [(MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1)-1:0] i_pos,
    input  gwmf_pkg::t_win_ctl          i_ctl,
    output gwmf_pkg::t_cand             o_cand
);
    import gwmf_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH = MAX_WIDTH * (1 << WW);

    logic [CELL_W-1:0]  r_store [DEPTH];
    logic [CELL_W-1:0]  r_store_q;
    logic [2*CNT_W-1:0] r_cnt_mem [MAX_WIDTH];
    logic [2*CNT_W-1:0] r_cnt_q;
    logic [MAX_WIDTH-1:0] r_cnt_vld;
    logic               r_vld_q;

    logic               r_s1_valid;
    logic [CELL_W-1:0]  r_s1_cell;
    logic [CW-1:0]      r_s1_col;
    logic [WW-1:0]      r_s1_pos;
    t_win_ctl           r_s1_ctl;
    logic               r_fwd_s;
    logic [CELL_W-1:0]  r_fwd_cell;
    logic               r_fwd_c;
    logic [2*CNT_W-1:0] r_fwd_cnt;

    logic [CELL_W-1:0]  old_cell;
    logic [2*CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0]   n_blk;
    logic [CNT_W-1:0]   n_fill;

    // column line store: one entry per column and window slot
    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            r_store[{r_s1_col, r_s1_pos}] <= r_s1_cell;
        end
        if (i_acc) begin
            r_store_q <= r_store[{i_col, i_pos}];
        end
    end

    // per-column counts, blocked count in the upper half
    always_ff @(posedge i_clk) begin
        if (i_adv && r_s1_valid) begin
            r_cnt_mem[r_s1_col] <= {n_blk, n_fill};
        end
        if (i_acc) begin
            r_cnt_q <= r_cnt_mem[i_col];
        end
    end

    // stage-one payload and forwarding from the entry in flight
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_cell  <= i_cell;
            r_s1_col   <= i_col;
            r_s1_pos   <= i_pos;
            r_s1_ctl   <= i_ctl;
            r_vld_q    <= r_cnt_vld[i_col];
            r_fwd_c    <= r_s1_valid && (r_s1_col == i_col);
            r_fwd_cnt  <= {n_blk, n_fill};
            r_fwd_s    <= r_s1_valid && (r_s1_col == i_col) && (r_s1_pos == i_pos);
            r_fwd_cell <= r_s1_cell;
        end
    end

    // leaving cell and updated column counts
    always_comb begin
        old_cell = r_fwd_s ? r_fwd_cell : r_store_q;
        if (r_s1_ctl.first) begin
            cnt_base = '0;
        end else if (r_fwd_c) begin
            cnt_base = r_fwd_cnt;
        end else if (r_vld_q) begin
            cnt_base = r_cnt_q;
        end else begin
            cnt_base = '0;
        end
        n_blk  = cnt_next(cnt_base[2*CNT_W-1:CNT_W], r_s1_ctl.sub,
                          old_cell, r_s1_cell, CELL_BLOCKED);
        n_fill = cnt_next(cnt_base[CNT_W-1:0], r_s1_ctl.sub,
                          old_cell, r_s1_cell, CELL_FILL);
    end

    // stage-one valid and count valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cnt_vld  <= '0;
        end else if (i_adv) begin
            r_s1_valid <= i_acc;
            if (r_s1_valid) begin
                r_cnt_vld[r_s1_col] <= 1'b1;
            end
        end
    end

    // full window with nothing blocked
    assign o_cand.ok   = r_s1_valid && r_s1_ctl.offer && (n_blk == '0);
    assign o_cand.fill = n_fill;

endmodule

### rtl/gwmf_mod_unit.sv
module gwmf_mod_unit #(
    parameter int RW = 11,
    parameter int CW = 8,
    parameter int WW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gwmf_pkg::WIN_W-1:0] i_divisor,
    input  logic [RW-1:0]              i_row,
    input  logic [CW-1:0]              i_col,
    output gwmf_pkg::t_mod_sts         o_sts,
    output logic [WW-1:0]              o_row_rem,
    output logic [WW-1:0]              o_col_rem
);
    import gwmf_pkg::*;

    localparam int DVW  = (RW > CW) ? RW : CW;
    localparam int CNTW = $clog2(DVW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNTW-1:0]  r_cnt;
    logic [DVW-1:0]   r_row_sh;
    logic [DVW-1:0]   r_col_sh;
    logic [REM_W-1:0] r_row_rem;
    logic [REM_W-1:0] r_col_rem;
    logic [WIN_W-1:0] r_div;

    // control: one dividend bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTW'(DVW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // restoring remainder of row and column index
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_row_sh  <= DVW'(i_row);
            r_col_sh  <= DVW'(i_col);
            r_row_rem <= '0;
            r_col_rem <= '0;
            r_div     <= i_divisor;
        end else if (r_busy) begin
            r_row_sh  <= {r_row_sh[DVW-2:0], 1'b0};
            r_col_sh  <= {r_col_sh[DVW-2:0], 1'b0};
            r_row_rem <= rem_step(r_row_rem, r_row_sh[DVW-1], r_div);
            r_col_rem <= rem_step(r_col_rem, r_col_sh[DVW-1], r_div);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_row_rem  = WW'(r_row_rem);
    assign o_col_rem  = WW'(r_col_rem);

endmodule

### rtl/gwmf_checker.sv
module gwmf_checker #(
    parameter int MAX_WINDOW = gwmf_pkg::MAX_WINDOW_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import gwmf_pkg::*;

    // a pending result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // a pending result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // no window found means a zero minimum and clean padding
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[15:1] == 15'd0)
        else $error("minimum set without a found window");

    // minimum never exceeds the longest window
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[9:1]) <= 32'(MAX_WINDOW))
        else $error("minimum beyond window length");

endmodule

bind grid_window_min_fill_search gwmf_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_gwmf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
